FILE: hdl/assert_macros.svh
// Assertion macros used by the cipher unit's datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is asserted.
`define KWSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define KWSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KWSC_ASSERT(lbl, clk, rstn, prop, msg)
`define KWSC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hdl/kwsc_pkg.sv
// Shared constants, helper function and controller/datapath interface types.
package kwsc_pkg;

    localparam int ALPHABET_SIZE_DEFAULT = 26;

    localparam logic [7:0] ROUNDS_RESET  = 8'd1;
    localparam logic [7:0] CHAR_A_LOWER  = 8'h61;
    localparam logic [7:0] CHAR_A_UPPER  = 8'h41;
    localparam logic [7:0] CHAR_Z_UPPER  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic key_update;
        logic fill_init;
        logic fill_step;
        logic key_commit;
        logic round_step;
        logic emit;
    } kwsc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_last;
        logic fill_done;
        logic rounds_done;
        logic out_free;
    } kwsc_status_t;

    // True when b is one of the first size lower-case letters.
    function automatic logic in_alphabet(input logic [7:0] b, input logic [7:0] size);
        logic [7:0] off;
        off = b - CHAR_A_LOWER;
        return (b >= CHAR_A_LOWER) && (off < size);
    endfunction

endpackage

FILE: hdl/keyword_substitution_cipher_unit.sv
// Keyword substitution cipher unit. Input beats are either key bytes (s_action low) or
// message bytes (s_action high). Key bytes are filtered for repeats and the distinct ones
// fill the substitution slots for 'a', 'b', ... in order; the key byte that carries s_last
// completes the table by walking the alphabet once, starting after the last distinct key
// byte if it is a letter (else at 'a') and wrapping, assigning each letter not yet used.
// Each key byte is accepted and then filtered; the final one also runs that completion walk.
// A message byte is first accepted, then passes once per round through the single
// lowercase-and-substitute unit; the block then notices the count has run out and hands the
// result to the output register. With no completed key in the table, a round only lowercases;
// with rounds at zero the byte passes unchanged. Only one item is in work at a time, but a
// finished result waits in the output register so the block is free to take the next
// input beat. The rounds register is written through the cfg channel, which is always
// ready and should be used only while the block is idle; it resets to one.
module keyword_substitution_cipher_unit
    import kwsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input item channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_char_value,
    input  logic       s_last,
    // Result channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    // Rounds register write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    kwsc_cmd_t    cmd;
    kwsc_status_t status;

    // The single register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller decides what happens in each cycle; the datapath holds all state.
    kwsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kwsc_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_action     (s_action),
        .s_char_value (s_char_value),
        .s_last       (s_last),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_char   (m_out_char)
    );

endmodule

FILE: hdl/kwsc_ctrl.sv
// Sequencing state machine of the keyword substitution cipher unit.
module kwsc_ctrl
    import kwsc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_action,
    output logic         s_ready,
    input  kwsc_status_t status,
    output kwsc_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_KEY   = 6'b000010,
        ST_FINIT = 6'b000100,
        ST_FILL  = 6'b001000,
        ST_ROUND = 6'b010000,
        ST_EMIT  = 6'b100000
    } kwsc_state_t;

    kwsc_state_t state_reg;
    kwsc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = s_action ? ST_ROUND : ST_KEY;
                end
            end
            ST_KEY: begin
                cmd.key_update = 1'b1;
                state_next     = status.item_last ? ST_FINIT : ST_IDLE;
            end
            ST_FINIT: begin
                cmd.fill_init = 1'b1;
                state_next    = ST_FILL;
            end
            ST_FILL: begin
                if (status.fill_done) begin
                    cmd.key_commit = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    cmd.fill_step = 1'b1;
                end
            end
            ST_ROUND: begin
                if (status.rounds_done) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.round_step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/kwsc_datapath.sv
// Key table, duplicate filter, table completion walk, round unit and output register.
`include "assert_macros.svh"

module kwsc_datapath
    import kwsc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  kwsc_cmd_t    cmd,
    output kwsc_status_t status,
    input  logic         s_action,
    input  logic [7:0]   s_char_value,
    input  logic         s_last,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_data,
    input  logic         m_ready,
    output logic         m_valid,
    output logic [7:0]   m_out_char
);

    localparam int IW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int KCW = $clog2(ALPHABET_SIZE + 1);
    localparam logic [KCW-1:0] KC_FULL  = KCW'(ALPHABET_SIZE);
    localparam logic [IW-1:0]  IDX_LAST = IW'(ALPHABET_SIZE - 1);
    localparam logic [7:0]     ASIZE8   = 8'(ALPHABET_SIZE);

    logic [7:0]     rounds_reg;
    logic [7:0]     round_cnt_reg;
    logic [7:0]     char_reg;
    logic           last_reg;
    logic [255:0]   seen_reg;
    logic           seen_hit_reg;
    logic [KCW-1:0] key_count_reg;
    logic [7:0]     last_kept_reg;
    logic           new_key_reg;
    logic           table_valid_reg;
    logic [ALPHABET_SIZE-1:0] used_reg;
    logic [7:0]     sub_table_reg [ALPHABET_SIZE];
    logic [IW-1:0]  fill_idx_reg;
    logic [KCW-1:0] fill_steps_reg;
    logic           out_valid_reg;
    logic [7:0]     out_char_reg;

    logic           key_start;
    logic           key_store;
    logic           key_alpha;
    logic [7:0]     key_off;
    logic           fill_write;
    logic [7:0]     fill_letter;
    logic [7:0]     start_off;
    logic           start_ok;
    logic [IW-1:0]  start_idx;
    logic [7:0]     lower_char;
    logic [7:0]     lower_off;
    logic [7:0]     round_char;

    // Key byte decode.
    assign key_start  = cmd.load && !s_action && new_key_reg;
    assign key_store  = cmd.key_update && !seen_hit_reg && (key_count_reg < KC_FULL);
    assign key_off    = char_reg - CHAR_A_LOWER;
    assign key_alpha  = in_alphabet(char_reg, ASIZE8);

    // Completion walk.
    assign start_off   = last_kept_reg - CHAR_A_LOWER;
    assign start_ok    = (key_count_reg != '0) && in_alphabet(last_kept_reg, ASIZE8);
    assign start_idx   = (!start_ok || start_off[IW-1:0] == IDX_LAST) ? '0
                                                                    : start_off[IW-1:0] + IW'(1);
    assign fill_write  = cmd.fill_step && !used_reg[fill_idx_reg];
    assign fill_letter = CHAR_A_LOWER + 8'(fill_idx_reg);

    // One round: fold upper case, then substitute an alphabet letter once the table is valid.
    assign lower_char = (char_reg >= CHAR_A_UPPER && char_reg <= CHAR_Z_UPPER)
                        ? char_reg + CASE_OFFSET : char_reg;
    assign lower_off  = lower_char - CHAR_A_LOWER;
    assign round_char = (table_valid_reg && in_alphabet(lower_char, ASIZE8))
                        ? sub_table_reg[lower_off[IW-1:0]] : lower_char;

    assign status.item_last   = last_reg;
    assign status.fill_done   = (key_count_reg == KC_FULL) || (fill_steps_reg == KC_FULL);
    assign status.rounds_done = (round_cnt_reg == '0);
    assign status.out_free    = !out_valid_reg || m_ready;

    assign m_valid    = out_valid_reg;
    assign m_out_char = out_char_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rounds_reg <= ROUNDS_RESET;
        end else if (cfg_valid) begin
            rounds_reg <= cfg_data;
        end
    end

    // Item capture and the round loop share the working byte register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            char_reg      <= s_char_value;
            last_reg      <= s_last;
            round_cnt_reg <= rounds_reg;
            seen_hit_reg  <= new_key_reg ? 1'b0 : seen_reg[s_char_value];
        end else if (cmd.round_step) begin
            char_reg      <= round_char;
            round_cnt_reg <= round_cnt_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg        <= '0;
            key_count_reg   <= '0;
            last_kept_reg   <= '0;
            new_key_reg     <= 1'b1;
            table_valid_reg <= 1'b0;
            used_reg        <= '0;
        end else if (key_start) begin
            seen_reg        <= '0;
            key_count_reg   <= '0;
            new_key_reg     <= 1'b0;
            table_valid_reg <= 1'b0;
            used_reg        <= '0;
        end else if (cmd.key_update) begin
            if (!seen_hit_reg) begin
                seen_reg[char_reg] <= 1'b1;
                last_kept_reg      <= char_reg;
            end
            if (key_store) begin
                key_count_reg <= key_count_reg + KCW'(1);
                if (key_alpha) begin
                    used_reg[key_off[IW-1:0]] <= 1'b1;
                end
            end
        end else if (fill_write) begin
            used_reg[fill_idx_reg] <= 1'b1;
            key_count_reg          <= key_count_reg + KCW'(1);
        end else if (cmd.key_commit) begin
            table_valid_reg <= 1'b1;
            new_key_reg     <= 1'b1;
        end
    end

    // Key bytes and completion letters both go to the slot after the last filled one.
    always_ff @(posedge aclk) begin
        if (key_store) begin
            sub_table_reg[key_count_reg[IW-1:0]] <= char_reg;
        end else if (fill_write) begin
            sub_table_reg[key_count_reg[IW-1:0]] <= fill_letter;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill_init) begin
            fill_idx_reg   <= start_idx;
            fill_steps_reg <= '0;
        end else if (cmd.fill_step) begin
            fill_idx_reg   <= (fill_idx_reg == IDX_LAST) ? '0 : fill_idx_reg + IW'(1);
            fill_steps_reg <= fill_steps_reg + KCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_char_reg <= char_reg;
        end
    end

    `KWSC_ASSERT(a_fill_stops, aclk, aresetn, !(cmd.fill_step && status.fill_done), "fill step issued after the table was complete")
    `KWSC_ASSERT(a_emit_room, aclk, aresetn, cmd.emit |-> (!out_valid_reg || m_ready), "result emitted over a beat still waiting")
    `KWSC_ASSERT(a_table_full, aclk, aresetn, table_valid_reg |-> (key_count_reg == KC_FULL), "table marked valid with empty slots")
    `KWSC_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !out_valid_reg, "output beat valid right after reset")

endmodule

FILE: bench/kwsc_checker.sv
// Scoreboard for the keyword substitution cipher unit, plus the action codes it shares with the bench top.
package kwsc_tb_pkg;

    typedef enum logic {
        ACT_KEY     = 1'b0,
        ACT_MESSAGE = 1'b1
    } kwsc_action_e;

endpackage

module kwsc_checker
    import kwsc_pkg::*;
    import kwsc_tb_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_char_value,
    input  logic       s_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending_results,
    output int         checked_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the cipher state.
    logic [7:0] rounds_reg;
    logic [7:0] cipher_table [26];
    logic       key_ready;
    logic       seen_key_byte [256];
    logic [4:0] key_slots;
    logic [7:0] last_distinct;
    logic       key_fresh;

    logic [7:0] expected_chars [$];
    logic [7:0] want;
    int         failures = 0;
    int         checked = 0;

    function automatic logic is_alpha_letter(input logic [7:0] b);
        return (b >= CHAR_A_LOWER) && (int'(b) - int'(CHAR_A_LOWER) < ALPHABET_SIZE);
    endfunction

    // Fills the slots the key left empty with unused letters, starting after the
    // last distinct key byte (or at 'a' if that is no letter) and wrapping round the alphabet.
    function automatic void fill_cipher_table();
        logic used [26];
        int   start;
        int   slot;
        int   idx;
        used = '{default: 1'b0};
        for (int j = 0; j < key_slots && j < 26; j++) begin
            if (is_alpha_letter(cipher_table[j]))
                used[int'(cipher_table[j] - CHAR_A_LOWER)] = 1'b1;
        end
        start = (key_slots > 0 && is_alpha_letter(last_distinct))
              ? int'(last_distinct) - int'(CHAR_A_LOWER) + 1 : 0;
        slot = key_slots;
        for (int j = 0; j < ALPHABET_SIZE && slot < ALPHABET_SIZE; j++) begin
            idx = (start + j) % ALPHABET_SIZE;
            if (!used[idx]) begin
                used[idx] = 1'b1;
                cipher_table[slot] = CHAR_A_LOWER + 8'(idx);
                slot++;
            end
        end
        key_slots = 5'(slot);
    endfunction

    function automatic void absorb_key_byte(input logic [7:0] b, input logic is_last);
        if (key_fresh) begin
            seen_key_byte = '{default: 1'b0};
            key_slots     = '0;
            key_ready     = 1'b0;
            key_fresh     = 1'b0;
        end
        if (!seen_key_byte[b]) begin
            seen_key_byte[b] = 1'b1;
            last_distinct    = b;
            if (key_slots < ALPHABET_SIZE) begin
                cipher_table[key_slots] = b;
                key_slots++;
            end
        end
        if (is_last) begin
            if (key_slots < ALPHABET_SIZE)
                fill_cipher_table();
            key_ready = 1'b1;
            key_fresh = 1'b1;
        end
    endfunction

    function automatic logic [7:0] encipher_byte(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        for (int r = 0; r < rounds_reg; r++) begin
            if (c >= CHAR_A_UPPER && c <= CHAR_Z_UPPER)
                c = c + CASE_OFFSET;
            if (key_ready && is_alpha_letter(c))
                c = cipher_table[c - CHAR_A_LOWER];
        end
        return c;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            rounds_reg    = ROUNDS_RESET;
            cipher_table  = '{default: 8'h00};
            key_ready     = 1'b0;
            seen_key_byte = '{default: 1'b0};
            key_slots     = '0;
            last_distinct = 8'h00;
            key_fresh     = 1'b1;
            expected_chars.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                rounds_reg = cfg_data;
            if (s_valid && s_ready) begin
                if (s_action == ACT_KEY)
                    absorb_key_byte(s_char_value, s_last);
                else
                    expected_chars.push_back(encipher_byte(s_char_value));
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual 0x%02h",
                             $time, m_out_char);
                    failures++;
                end else begin
                    want = expected_chars.pop_front();
                    checked++;
                    if (m_out_char !== want) begin
                        $display("%0t: out_char mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, want, m_out_char);
                        failures++;
                    end
                end
            end
        end
        fail_count      <= failures;
        pending_results <= expected_chars.size();
        checked_results <= checked;
    end

endmodule

FILE: bench/keyword_substitution_cipher_unit_tb.sv
// Stimulus and verdict for the keyword substitution cipher unit.
module keyword_substitution_cipher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kwsc_pkg::*;
    import kwsc_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_TIME  = 300;
    // Key bytes produce no result, so after the last result the table fill
    // may still be running; this settle time lets it finish.
    localparam int FILL_SETTLE  = 40;

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic       s_action     = 1'b0;
    logic [7:0] s_char_value = 8'h00;
    logic       s_last       = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_out_char;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data     = 8'h00;

    int fail_count;
    int pending_results;
    int checked_results;

    int cycle_count     = 0;
    int items_sent      = 0;
    int key_beats       = 0;
    int message_beats   = 0;
    int keys_closed     = 0;
    int rounds_settings = 1;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    always #5 aclk = ~aclk;

    keyword_substitution_cipher_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_char_value (s_char_value),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // The checker sees the same three channels as the block and reports back
    // how many results are still outstanding and how many went wrong.
    kwsc_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_char_value    (s_char_value),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .checked_results (checked_results)
    );

    // Idle length in cycles: usually none or short, now and then long. A
    // steady side never idles, which gives back-to-back stretches.
    function automatic int idle_length(input bit steady);
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_letter();
        return CHAR_A_LOWER + 8'($urandom_range(0, ALPHABET_SIZE_DEFAULT - 1));
    endfunction

    // Message bytes lean toward letters of both cases, since those are the
    // ones that get lowercased and substituted.
    function automatic logic [7:0] random_message_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return random_letter();
        else if (pick < 70)
            return CHAR_A_UPPER + 8'($urandom_range(0, 25));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_key_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return random_letter();
        else if (pick < 80)
            return CHAR_A_UPPER + 8'($urandom_range(0, 25));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Presents one input beat and returns at the edge where it is taken.
    // With no gap the valid simply stays high from the previous beat, so it
    // is never lowered and raised within one time step.
    task automatic send_beat(input kwsc_action_e act, input logic [7:0] ch, input logic lst);
        int gap;
        gap = idle_length(sender_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_char_value <= ch;
        s_last       <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (act == ACT_KEY)
            key_beats++;
        else
            message_beats++;
    endtask

    // Holds the sender off until every predicted result has been seen. The
    // first edge lets the checker count a beat taken at the current edge.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // The rounds register is only touched with the block idle, including
    // any table fill still running after the final key byte.
    task automatic write_rounds(input logic [7:0] value);
        drain_results();
        repeat (FILL_SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        rounds_settings++;
    endtask

    // One key of a randomly chosen shape: short letter keys, a full shuffled
    // alphabet, long keys that overflow the table, mixed bytes, and keys
    // that end on a byte outside the alphabet. A few message beats are slipped
    // in while the key is still being entered.
    task automatic send_random_key();
        logic [7:0] key_bytes [$];
        logic [7:0] swap;
        int         style;
        int         len;
        int         k;
        style = $urandom_range(0, 99);
        if (style < 50) begin
            len = $urandom_range(1, 10);
            repeat (len) key_bytes.push_back(random_letter());
        end else if (style < 62) begin
            for (int i = 0; i < 26; i++)
                key_bytes.push_back(CHAR_A_LOWER + 8'(i));
            for (int i = 25; i > 0; i--) begin
                k = $urandom_range(0, i);
                swap         = key_bytes[i];
                key_bytes[i] = key_bytes[k];
                key_bytes[k] = swap;
            end
        end else if (style < 72) begin
            len = $urandom_range(27, 40);
            repeat (len) key_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (style < 88) begin
            len = $urandom_range(1, 8);
            repeat (len) key_bytes.push_back(random_key_byte());
        end else begin
            len = $urandom_range(0, 6);
            repeat (len) key_bytes.push_back(random_letter());
            if ($urandom_range(0, 1) == 0)
                key_bytes.push_back(CHAR_A_UPPER + 8'($urandom_range(0, 25)));
            else
                key_bytes.push_back(8'($urandom_range(123, 255)));
        end
        foreach (key_bytes[i]) begin
            if (i != 0 && $urandom_range(0, 99) < 6)
                send_beat(ACT_MESSAGE, random_message_byte(), 1'b0);
            send_beat(ACT_KEY, key_bytes[i], i == key_bytes.size() - 1);
        end
        keys_closed++;
    endtask

    // Mostly a key followed by a run of message bytes; the rest is noise
    // with every field random, which also leaves keys open and unfinished.
    task automatic run_phase(input int quota);
        int target;
        int n;
        target = items_sent + quota;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 12) begin
                n = $urandom_range(1, 5);
                repeat (n) send_beat(kwsc_action_e'($urandom_range(0, 1)),
                                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                send_random_key();
                n = $urandom_range(2, 16);
                repeat (n) send_beat(ACT_MESSAGE, random_message_byte(),
                                     1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) < 4)
                drain_results();
            if ($urandom_range(0, 99) < 15)
                sender_steady = ~sender_steady;
            if ($urandom_range(0, 99) < 15)
                receiver_steady = ~receiver_steady;
        end
    endtask

    // Result side: random stalls between random stretches of readiness.
    initial begin
        int hold;
        wait (aresetn);
        forever begin
            hold = idle_length(receiver_steady);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats at the reset rounds value of one. Before any key,
        // bytes are only lowercased; extremes of the byte range pass through.
        send_beat(ACT_MESSAGE, CHAR_A_UPPER, 1'b0);
        send_beat(ACT_MESSAGE, 8'h00, 1'b1);
        send_beat(ACT_MESSAGE, 8'hFF, 1'b0);
        send_beat(ACT_MESSAGE, "z", 1'b0);
        // A message beat in the middle of a key sees no table yet. The repeat
        // is dropped, and the key ends on a non-letter so the fill starts at 'a'.
        send_beat(ACT_KEY, "k", 1'b0);
        send_beat(ACT_MESSAGE, "M", 1'b0);
        send_beat(ACT_KEY, "e", 1'b0);
        send_beat(ACT_KEY, "e", 1'b0);
        send_beat(ACT_KEY, 8'hFF, 1'b1);
        send_beat(ACT_MESSAGE, "a", 1'b0);
        send_beat(ACT_MESSAGE, "Z", 1'b0);
        send_beat(ACT_MESSAGE, "{", 1'b0);
        send_beat(ACT_MESSAGE, "k", 1'b0);
        // A key ending on 'z' makes the fill wrap straight back to 'a'.
        send_beat(ACT_KEY, "q", 1'b0);
        send_beat(ACT_KEY, "z", 1'b1);
        send_beat(ACT_MESSAGE, "y", 1'b0);
        send_beat(ACT_MESSAGE, "Q", 1'b0);
        // Single-byte keys outside the alphabet: high byte and upper case.
        send_beat(ACT_KEY, 8'h80, 1'b1);
        send_beat(ACT_MESSAGE, "b", 1'b0);
        send_beat(ACT_KEY, "Z", 1'b1);
        send_beat(ACT_MESSAGE, "c", 1'b0);
        keys_closed += 4;

        // Random phases, each under its own rounds value. The 255 phase is
        // kept short since message beats there are the slowest of the run.
        run_phase(250);
        write_rounds(8'd0);
        run_phase(150);
        write_rounds(8'd255);
        run_phase(100);
        write_rounds(8'd2);
        run_phase(250);
        write_rounds(8'($urandom_range(4, 254)));
        run_phase(200);
        write_rounds(8'd3);
        run_phase(200);
        write_rounds(8'd1);
        run_phase(100);

        drain_results();
        repeat (SETTLE_TIME) @(posedge aclk);

        $display("Covered %0d key beats closing %0d keys and %0d message beats, under %0d rounds settings from 0 to 255.",
                 key_beats, keys_closed, message_beats, rounds_settings);
        $display("Compared %0d enciphered bytes, %0d of them wrong.",
                 checked_results, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
